### hdl/bssp_pkg.sv
// bssp_pkg: shared constants, types and helpers for the bounded subset sum plate fill block
// no dependencies; every other file uses this package by scoped names

package bssp_pkg;

	localparam int unsigned MAX_LOAD       = 191;
	localparam int unsigned UNLIMITED_CODE = 15;
	localparam int unsigned HAVE_RESET     = 15;
	localparam int unsigned NSIZES         = 8;
	localparam int unsigned LOAD_W         = 8;
	localparam int unsigned HAVE_W         = 4;
	localparam int unsigned APB_AW         = $clog2(NSIZES) + 2;

	typedef logic [MAX_LOAD:0]               reach_set_t;
	typedef logic [LOAD_W-1:0]               load_t;
	typedef logic [$clog2(NSIZES)-1:0]       size_idx_t;
	typedef logic [HAVE_W-1:0]               have_t;
	typedef logic [NSIZES-1:0][HAVE_W-1:0]   have_arr_t;

	// bitset unit opcodes
	typedef logic [1:0] op_t;
	localparam op_t OP_HOLD   = 2'd0;
	localparam op_t OP_INIT   = 2'd1;
	localparam op_t OP_STEP   = 2'd2;
	localparam op_t OP_RELOAD = 2'd3;

	typedef struct packed {
		op_t       op;
		size_idx_t idx;
	} unit_cmd_t;

	// item size in units, heaviest at index 0
	function automatic logic [4:0] size_units(size_idx_t idx);
		logic [4:0] u;
		unique case (idx)
			3'd0: u = 5'd22;
			3'd1: u = 5'd18;
			3'd2: u = 5'd14;
			3'd3: u = 5'd10;
			3'd4: u = 5'd6;
			3'd5: u = 5'd4;
			3'd6: u = 5'd2;
			3'd7: u = 5'd1;
		endcase
		return u;
	endfunction

	function automatic logic is_unlimited(have_t h);
		return h >= HAVE_W'(UNLIMITED_CODE);
	endfunction

endpackage

### hdl/bssp_if.sv
// bssp_if: valid/ready channel interfaces for the request and result items
// depends on bssp_pkg for the load width

interface bssp_req_if;
	logic                 valid;
	logic                 ready;
	bssp_pkg::load_t      goal_load;

	modport source (output valid, output goal_load, input ready);
	modport sink   (input valid, input goal_load, output ready);
endinterface

interface bssp_rsp_if;
	logic                 valid;
	logic                 ready;
	bssp_pkg::load_t      best_sum;
	logic [3:0]           take_size22;
	logic [3:0]           take_size18;
	logic [3:0]           take_size14;
	logic [4:0]           take_size10;
	logic [4:0]           take_size6;
	logic [5:0]           take_size4;
	logic [6:0]           take_size2;
	logic [7:0]           take_size1;

	modport source (output valid, output best_sum, output take_size22, output take_size18,
		output take_size14, output take_size10, output take_size6, output take_size4,
		output take_size2, output take_size1, input ready);
	modport sink   (input valid, input best_sum, input take_size22, input take_size18,
		input take_size14, input take_size10, input take_size6, input take_size4,
		input take_size2, input take_size1, output ready);
endinterface

### hdl/bssp_cfg.sv
// bssp_cfg: apb register bank holding the eight inventory registers
// depends on bssp_pkg

module bssp_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bssp_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output bssp_pkg::have_arr_t          have
);

	bssp_pkg::have_arr_t have_q;
	bssp_pkg::size_idx_t reg_idx;
	logic                wr_en;

	assign reg_idx = paddr[bssp_pkg::APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign prdata  = {{(32 - bssp_pkg::HAVE_W){1'b0}}, have_q[reg_idx]};
	assign have    = have_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bssp_pkg::NSIZES; i++) begin
				have_q[i] <= bssp_pkg::HAVE_W'(bssp_pkg::HAVE_RESET);
			end
		end else if (wr_en) begin
			have_q[reg_idx] <= pwdata[bssp_pkg::HAVE_W-1:0];
		end
	end

endmodule

### hdl/bssp_bitset_unit.sv
// bssp_bitset_unit: shared shift-or unit over the reachable-sum bitset
// depends on bssp_pkg; driven by bssp_seq one command per cycle

module bssp_bitset_unit (
	input  logic                  clk,
	input  bssp_pkg::unit_cmd_t   cmd,
	output bssp_pkg::reach_set_t  acc
);

	bssp_pkg::reach_set_t term_q;
	bssp_pkg::reach_set_t acc_q;
	bssp_pkg::reach_set_t term_shift;

	// one more copy of the current size moves every partial sum up by u
	assign term_shift = term_q << bssp_pkg::size_units(cmd.idx);
	assign acc        = acc_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bssp_pkg::OP_INIT: begin
				term_q <= bssp_pkg::reach_set_t'(1);
				acc_q  <= bssp_pkg::reach_set_t'(1);
			end
			bssp_pkg::OP_STEP: begin
				term_q <= term_shift;
				acc_q  <= acc_q | term_shift;
			end
			bssp_pkg::OP_RELOAD: begin
				term_q <= acc_q;
			end
			bssp_pkg::OP_HOLD: begin
			end
		endcase
	end

endmodule

### hdl/bssp_seq.sv
// bssp_seq: sequencer for bitset build, best-sum search and count reconstruction
// depends on bssp_pkg, bssp_if and bssp_bitset_unit (via the cmd/acc pair)

module bssp_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	bssp_req_if.sink              req,
	bssp_rsp_if.source            rsp,
	input  bssp_pkg::have_arr_t   have,
	output bssp_pkg::unit_cmd_t   cmd,
	input  bssp_pkg::reach_set_t  acc
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_BUILD  = 3'd1;
	localparam logic [2:0] ST_SEARCH = 3'd2;
	localparam logic [2:0] ST_RECON  = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]                                   state_q;
	bssp_pkg::size_idx_t                          idx_q;
	bssp_pkg::load_t                              target_q;
	bssp_pkg::load_t                              k_q;
	bssp_pkg::load_t                              kt_q;
	bssp_pkg::load_t                              load_q;
	bssp_pkg::load_t                              rem_q;
	bssp_pkg::load_t                              best_q;
	bssp_pkg::load_t                              best_rem_q;
	bssp_pkg::reach_set_t [bssp_pkg::NSIZES-1:0]  reach_q;
	bssp_pkg::load_t   [bssp_pkg::NSIZES-1:0]     takes_q;
	logic                                         out_valid_q;
	bssp_pkg::load_t                              out_best_q;
	bssp_pkg::load_t   [bssp_pkg::NSIZES-1:0]     out_take_q;

	bssp_pkg::load_t      u;
	bssp_pkg::have_t      h;
	logic                 under_have;
	logic                 build_go;
	logic                 recon_go;
	bssp_pkg::load_t      rem_dec;
	bssp_pkg::reach_set_t src;
	logic                 src_hit;
	logic                 search_hit;
	logic                 accept;
	logic                 emit_fire;
	bssp_pkg::load_t      target_clamp;

	assign u          = {3'b000, bssp_pkg::size_units(idx_q)};
	assign h          = have[idx_q];
	assign under_have = bssp_pkg::is_unlimited(h) || (k_q < {4'b0000, h});
	assign build_go   = under_have && (({1'b0, kt_q} + {1'b0, u}) <= {1'b0, target_q});
	assign recon_go   = under_have && (rem_q >= u);
	assign rem_dec    = rem_q - u;
	// lightest size is built only from the empty set
	assign src        = (idx_q == 3'd7) ? bssp_pkg::reach_set_t'(1) : reach_q[idx_q + 3'd1];
	assign src_hit    = src[rem_dec];
	assign search_hit = reach_q[0][load_q];

	assign accept       = req.valid && req.ready;
	assign emit_fire    = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);
	assign target_clamp = (req.goal_load > bssp_pkg::LOAD_W'(bssp_pkg::MAX_LOAD)) ?
		bssp_pkg::LOAD_W'(bssp_pkg::MAX_LOAD) : req.goal_load;

	assign req.ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.idx = idx_q;
		cmd.op  = bssp_pkg::OP_HOLD;
		if (accept) begin
			cmd.op = bssp_pkg::OP_INIT;
		end else if (state_q == ST_BUILD) begin
			cmd.op = build_go ? bssp_pkg::OP_STEP : bssp_pkg::OP_RELOAD;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one taken at the same edge
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_BUILD;
						idx_q   <= 3'd7;
					end
				end
				ST_BUILD: begin
					if (!build_go) begin
						if (idx_q == 3'd0) begin
							state_q <= ST_SEARCH;
						end else begin
							idx_q <= idx_q - 3'd1;
						end
					end
				end
				ST_SEARCH: begin
					if (load_q == '0 || search_hit) begin
						state_q <= ST_RECON;
						idx_q   <= '0;
					end
				end
				ST_RECON: begin
					if (!recon_go) begin
						if (idx_q == 3'd7) begin
							state_q <= ST_EMIT;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					target_q <= target_clamp;
					k_q      <= '0;
					kt_q     <= '0;
				end
			end
			ST_BUILD: begin
				if (build_go) begin
					k_q  <= k_q + 8'd1;
					kt_q <= kt_q + u;
				end else begin
					reach_q[idx_q] <= acc;
					k_q            <= '0;
					kt_q           <= '0;
					load_q         <= target_q;
				end
			end
			ST_SEARCH: begin
				if (load_q == '0 || search_hit) begin
					rem_q      <= load_q;
					best_rem_q <= load_q;
					best_q     <= '0;
					k_q        <= '0;
				end else begin
					load_q <= load_q - 8'd1;
				end
			end
			ST_RECON: begin
				if (recon_go) begin
					k_q   <= k_q + 8'd1;
					rem_q <= rem_dec;
					if (src_hit) begin
						best_q     <= k_q + 8'd1;
						best_rem_q <= rem_dec;
					end
				end else begin
					takes_q[idx_q] <= best_q;
					rem_q          <= best_rem_q;
					best_q         <= '0;
					k_q            <= '0;
				end
			end
			ST_EMIT: begin
				if (emit_fire) begin
					out_best_q <= load_q;
					out_take_q <= takes_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.best_sum    = out_best_q;
	assign rsp.take_size22 = out_take_q[0][3:0];
	assign rsp.take_size18 = out_take_q[1][3:0];
	assign rsp.take_size14 = out_take_q[2][3:0];
	assign rsp.take_size10 = out_take_q[3][4:0];
	assign rsp.take_size6  = out_take_q[4][4:0];
	assign rsp.take_size4  = out_take_q[5][5:0];
	assign rsp.take_size2  = out_take_q[6][6:0];
	assign rsp.take_size1  = out_take_q[7];

	a_accept_starts_build: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_BUILD && idx_q == 3'd7))
		else $error("accepted item did not start the build");

	a_build_within_stock: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUILD && !bssp_pkg::is_unlimited(h)) |-> (k_q <= {4'b0000, h}))
		else $error("build used more items than in stock");

	a_search_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (load_q <= target_q))
		else $error("search above target");

	a_best_within_target: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> (out_best_q <= target_q))
		else $error("best sum above target");

	a_counts_add_up: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> ({4'b0000, out_best_q} ==
			12'd22 * {4'b0000, out_take_q[0]} + 12'd18 * {4'b0000, out_take_q[1]} +
			12'd14 * {4'b0000, out_take_q[2]} + 12'd10 * {4'b0000, out_take_q[3]} +
			12'd6  * {4'b0000, out_take_q[4]} + 12'd4  * {4'b0000, out_take_q[5]} +
			12'd2  * {4'b0000, out_take_q[6]} + {4'b0000, out_take_q[7]}))
		else $error("item counts do not add up to the best sum");

endmodule

### hdl/bounded_subset_sum_plate_fill_top.sv
// bounded_subset_sum_plate_fill_top: top level of the bounded subset sum plate fill block
// depends on bssp_pkg, bssp_if, bssp_cfg, bssp_bitset_unit and bssp_seq
//
//  port   kind        dir   fields
//  req    valid/ready sink  goal_load[7:0]
//  rsp    valid/ready src   best_sum[7:0], take_size22..take_size1
//  apb    psel/penable cfg  paddr[4:0] = 4*index, pwdata[3:0] -> have_sizeN
//
// per item: the build folds lim = min(stock, target/size) copies of each size into the set,
// the search walks down from the target to the best reachable sum, the rebuild tries
// steps = min(stock, remainder/size) copies of each size, and an emit step loads the result;
// the single shift-or unit and the rebuild walk, one copy at a time, set the processing time
// req.ready is high only while the sequencer is idle; one item is in flight at a time
// the result sits in an output register, so the next item is taken while rsp is stalled
// arst_n clears the sequencer and the output valid, inventory registers reset to unlimited
// no clearing pass: the scratch bitsets are rebuilt from scratch for every item

module bounded_subset_sum_plate_fill_top (
	input  logic                         clk,
	input  logic                         arst_n,
	bssp_req_if.sink                     req,
	bssp_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bssp_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	// inventory per size, heaviest first
	bssp_pkg::have_arr_t  have;
	// sequencer to shift-or unit
	bssp_pkg::unit_cmd_t  cmd;
	// running reachable-sum set
	bssp_pkg::reach_set_t acc;

	bssp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.have    (have)
	);

	// one shift-or per cycle while building, between reloads: folds one more copy of the current size into the set
	bssp_bitset_unit u_unit (
		.clk (clk),
		.cmd (cmd),
		.acc (acc)
	);

	// build lightest size first, search down from target, then rebuild counts heaviest first
	bssp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.have   (have),
		.cmd    (cmd),
		.acc    (acc)
	);

endmodule
